/* rtl/accel_shake_detector_assert.svh */
// ----------------------------------------------------------------------------
// accel_shake_detector_assert.svh
// assertion macros used by the shake detector checker
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_DETECTOR_ASSERT_SVH
`define ACCEL_SHAKE_DETECTOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ASD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("asd assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("asd assertion failed: next-cycle implication");

`endif

/* rtl/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// widths, reset values and register codes of the shake detector
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int AVG_FRAC_BITS  = 8;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GRAV_BITS      = SAMPLE_BITS + AVG_FRAC_BITS + 1;
  localparam int RES_BITS       = GRAV_BITS + 1;
  localparam int GAIN_BITS      = 9;
  localparam int PROD_BITS      = RES_BITS + GAIN_BITS + 1;
  localparam int DELTA_BITS     = PROD_BITS - GAIN_FRAC_BITS;
  localparam int SUM_BITS       = DELTA_BITS + 1;
  localparam int MAG_BITS       = RES_BITS - 1;
  localparam int SQ_BITS        = 2 * MAG_BITS;
  localparam int ENERGY_BITS    = SQ_BITS + 2;
  localparam int ENERGY_HI_BITS = ENERGY_BITS - 2 * AVG_FRAC_BITS;
  localparam int THR_BITS       = 34;
  localparam int REFR_BITS      = 32;
  localparam int TIME_BITS      = 63;
  localparam int QUIET_BITS     = 64;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 34;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(51);
  localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(32883343);
  localparam logic [REFR_BITS-1:0] REFR_RESET = REFR_BITS'(1000000);

  localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_GAIN   = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_SQ  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_REFRACTORY_US = CFG_IDX_BITS'(2);

  typedef struct packed {
    logic signed [GRAV_BITS-1:0] grav_nxt;
    logic        [SQ_BITS-1:0]   sq;
  } asd_axis_t;

endpackage

/* rtl/accel_shake_detector.sv */
// ----------------------------------------------------------------------------
// accel_shake_detector
// shake detection on a three-axis accelerometer stream
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one sample transaction:
//   x, y, z acceleration and a microsecond timestamp. the result channel
//   (out_valid / out_stall) returns one transaction per sample with
//   out_shake_seen set when the sample is a qualified shake.
//   a sample accepted into the input register has its result loaded into
//   the result register once that register is empty or the receiver does
//   not stall, and out_valid then rises. one sample is taken every cycle
//   while in_stall is low. residual, gain update, squares, energy
//   sum and both compares run in one pass between the two registers, so the
//   gravity average and the refractory window close their loops there.
//   the input and result registers each absorb a bubble, so in_stall rises
//   only when both hold data and the receiver stalls.
//   reset (rst_n low, synchronous) empties both registers, clears the
//   averages and the refractory window, and loads the register defaults.
//   the first sample after reset primes the averages and never shakes.
//   config writes (cfg_we) are taken at once and belong to idle periods.
// ----------------------------------------------------------------------------
module accel_shake_detector (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [asd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [asd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_z,
  input  logic [asd_pkg::TIME_BITS-1:0]          in_time_us,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_shake_seen
);

  // configuration registers
  logic [asd_pkg::GAIN_BITS-1:0] gain_r;
  logic [asd_pkg::THR_BITS-1:0]  thr_r;
  logic [asd_pkg::REFR_BITS-1:0] refr_r;

  // detector state
  logic signed [asd_pkg::GRAV_BITS-1:0] grav_x_r, grav_y_r, grav_z_r;
  logic                                 primed_r;
  logic [asd_pkg::QUIET_BITS-1:0]       quiet_end_r;
  logic [asd_pkg::QUIET_BITS-1:0]       quiet_end_nxt;

  // input register
  logic                                   s0_v_r;
  logic signed [asd_pkg::SAMPLE_BITS-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic [asd_pkg::TIME_BITS-1:0]          s0_time_r;

  // result register
  logic out_v_r;
  logic out_shake_r;
  logic shake_nxt;

  logic ld_out, ld0;
  logic s0_fire;

  asd_pkg::asd_axis_t ax_x, ax_y, ax_z;

  logic [asd_pkg::ENERGY_BITS-1:0]    energy;
  logic [asd_pkg::ENERGY_HI_BITS-1:0] energy_hi;
  logic                               energy_hit;
  logic                               window_open;

  // each register loads when empty or when its content moves on
  assign ld_out   = !out_v_r || !out_stall;
  assign ld0      = !s0_v_r || ld_out;
  assign in_stall = !ld0;
  assign s0_fire  = s0_v_r && ld_out;

  // per-axis residual, average update and square
  asd_axis u_axis_x (
    .sample (s0_x_r),
    .grav   (grav_x_r),
    .gain   (gain_r),
    .primed (primed_r),
    .res    (ax_x)
  );

  asd_axis u_axis_y (
    .sample (s0_y_r),
    .grav   (grav_y_r),
    .gain   (gain_r),
    .primed (primed_r),
    .res    (ax_y)
  );

  asd_axis u_axis_z (
    .sample (s0_z_r),
    .grav   (grav_z_r),
    .gain   (gain_r),
    .primed (primed_r),
    .res    (ax_z)
  );

  // residual energy, cannot overflow at these widths
  assign energy      = asd_pkg::ENERGY_BITS'(ax_x.sq) + asd_pkg::ENERGY_BITS'(ax_y.sq)
                     + asd_pkg::ENERGY_BITS'(ax_z.sq);
  assign energy_hi   = energy[asd_pkg::ENERGY_BITS-1:2*asd_pkg::AVG_FRAC_BITS];
  assign energy_hit  = energy_hi >= asd_pkg::ENERGY_HI_BITS'(thr_r);
  assign window_open = asd_pkg::QUIET_BITS'(s0_time_r) >= quiet_end_r;
  // the priming sample never shakes
  assign shake_nxt   = primed_r && energy_hit && window_open;

  // 63-bit time plus 32-bit window never wraps 64 bits
  assign quiet_end_nxt = asd_pkg::QUIET_BITS'(s0_time_r) + asd_pkg::QUIET_BITS'(refr_r);

  // control state and config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= asd_pkg::GAIN_RESET;
      thr_r       <= asd_pkg::THR_RESET;
      refr_r      <= asd_pkg::REFR_RESET;
      grav_x_r    <= '0;
      grav_y_r    <= '0;
      grav_z_r    <= '0;
      primed_r    <= 1'b0;
      quiet_end_r <= '0;
      s0_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          asd_pkg::REG_FOLLOW_GAIN:   gain_r <= cfg_wdata[asd_pkg::GAIN_BITS-1:0];
          asd_pkg::REG_THRESHOLD_SQ:  thr_r  <= cfg_wdata[asd_pkg::THR_BITS-1:0];
          asd_pkg::REG_REFRACTORY_US: refr_r <= cfg_wdata[asd_pkg::REFR_BITS-1:0];
          default: ;
        endcase
      end
      if (ld0) begin
        s0_v_r <= in_valid;
      end
      if (ld_out) begin
        out_v_r <= s0_v_r;
      end
      // average update and window as the sample leaves the input register
      if (s0_fire) begin
        grav_x_r <= ax_x.grav_nxt;
        grav_y_r <= ax_y.grav_nxt;
        grav_z_r <= ax_z.grav_nxt;
        primed_r <= 1'b1;
        // a shake opens a new quiet window
        if (shake_nxt) begin
          quiet_end_r <= quiet_end_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld0) begin
      s0_x_r    <= in_accel_x;
      s0_y_r    <= in_accel_y;
      s0_z_r    <= in_accel_z;
      s0_time_r <= in_time_us;
    end
    if (ld_out) begin
      out_shake_r <= shake_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_shake_seen = out_shake_r;

endmodule

/* rtl/asd_axis.sv */
// ----------------------------------------------------------------------------
// asd_axis
// one axis: residual against the average, gain update and residual square
// ----------------------------------------------------------------------------
module asd_axis (
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [asd_pkg::GRAV_BITS-1:0]   grav,
  input  logic        [asd_pkg::GAIN_BITS-1:0]   gain,
  input  logic                                   primed,
  output asd_pkg::asd_axis_t                     res
);

  localparam int GB = asd_pkg::GRAV_BITS;
  localparam int RB = asd_pkg::RES_BITS;
  localparam int PB = asd_pkg::PROD_BITS;
  localparam int SB = asd_pkg::SUM_BITS;
  localparam logic signed [SB-1:0] GRAV_MAX = SB'((64'sd1 <<< (GB - 1)) - 64'sd1);
  localparam logic signed [SB-1:0] GRAV_MIN = SB'(-(64'sd1 <<< (GB - 1)));
  localparam logic signed [PB-1:0] ROUND_HALF =
    PB'(64'sd1 <<< (asd_pkg::GAIN_FRAC_BITS - 1));

  logic signed [GB-1:0]                    scaled;
  logic signed [RB-1:0]                    resid;
  logic signed [asd_pkg::GAIN_BITS:0]      gain_s;
  logic signed [PB-1:0]                    prod;
  logic signed [PB-1:0]                    rnd;
  logic signed [asd_pkg::DELTA_BITS-1:0]   delta;
  logic signed [SB-1:0]                    sum;
  logic signed [GB-1:0]                    sat;
  logic        [asd_pkg::MAG_BITS-1:0]     mag;
  logic signed [RB-1:0]                    neg;

  // sample in average units
  assign scaled = {{(GB - asd_pkg::SAMPLE_BITS - asd_pkg::AVG_FRAC_BITS){sample[
                    asd_pkg::SAMPLE_BITS-1]}}, sample, {asd_pkg::AVG_FRAC_BITS{1'b0}}};

  assign resid  = $signed({scaled[GB-1], scaled}) - $signed({grav[GB-1], grav});
  assign gain_s = $signed({1'b0, gain});
  assign prod   = PB'(resid) * PB'(gain_s);
  assign rnd    = prod + ROUND_HALF;
  // arithmetic shift gives floor, so round half up
  assign delta  = rnd[PB-1:asd_pkg::GAIN_FRAC_BITS];
  assign sum    = SB'(grav) + SB'(delta);

  always_comb begin
    if (sum > GRAV_MAX) begin
      sat = GB'(GRAV_MAX);
    end else if (sum < GRAV_MIN) begin
      sat = GB'(GRAV_MIN);
    end else begin
      sat = GB'(sum);
    end
  end

  assign neg = -resid;
  assign mag = resid[RB-1] ? neg[asd_pkg::MAG_BITS-1:0] : resid[asd_pkg::MAG_BITS-1:0];

  assign res.grav_nxt = primed ? sat : scaled;
  assign res.sq       = mag * mag;

endmodule

/* rtl/asd_chk.sv */
// ----------------------------------------------------------------------------
// asd_chk
// port-level checks on the shake detector handshakes
// ----------------------------------------------------------------------------
`include "accel_shake_detector_assert.svh"

module asd_chk (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a stalled result transaction stays offered
  `ASD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // backpressure on the input only comes from a blocked result side
  `ASD_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // a full pipeline still has a result waiting in the next cycle
  `ASD_ASSERT_NEXT(a_stall_result, clk, rst_n, in_stall, out_valid)

endmodule

bind accel_shake_detector asd_chk u_asd_chk (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression for the accelerometer shake detector
// ----------------------------------------------------------------------------
// drives sample transactions through the valid/stall input channel, keeps
// its own gravity-average and refractory-window model of the block and
// compares every result transaction with the oldest predicted shake flag.
// a short directed part covers field extremes, priming, zero and maximum
// thresholds, gain extremes with saturation and window boundaries; random
// phases then mix realistic motion with spikes under changing settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES = 80;    // long receiver hold for the fill-up test
  localparam int TAIL_CYCLES = 6;     // short tail after the last result comes back
  localparam int DEAD_LIMIT  = 4000;  // cycles with no transaction on either side

  localparam logic [asd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = asd_pkg::CFG_IDX_BITS'(3);

  localparam longint GRAV_ONE  = longint'(1) << asd_pkg::AVG_FRAC_BITS;
  localparam longint GAIN_HALF = longint'(1) << (asd_pkg::GAIN_FRAC_BITS - 1);
  localparam longint GRAV_MAX  = (longint'(1) << (asd_pkg::GRAV_BITS - 1)) - 1;
  localparam longint GRAV_MIN  = -GRAV_MAX - 1;

  typedef struct {
    logic signed [asd_pkg::SAMPLE_BITS-1:0] ax;
    logic signed [asd_pkg::SAMPLE_BITS-1:0] ay;
    logic signed [asd_pkg::SAMPLE_BITS-1:0] az;
    logic [asd_pkg::TIME_BITS-1:0]          t;
  } sample_t;

  // dut ports
  logic                                   clk;
  logic                                   rst_n;
  logic                                   cfg_we;
  logic [asd_pkg::CFG_IDX_BITS-1:0]       cfg_index;
  logic [asd_pkg::CFG_DATA_BITS-1:0]      cfg_wdata;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_x;
  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_y;
  logic signed [asd_pkg::SAMPLE_BITS-1:0] in_accel_z;
  logic [asd_pkg::TIME_BITS-1:0]          in_time_us;
  logic                                   out_valid;
  logic                                   out_stall;
  logic                                   out_shake_seen;

  // model state: gravity estimates in Q16.8, priming and refractory window
  longint                        gravity_est [3];
  bit                            primed;
  logic [63:0]                   quiet_end_us;
  logic [asd_pkg::GAIN_BITS-1:0] follow_gain;
  logic [asd_pkg::THR_BITS-1:0]  threshold_sq;
  logic [asd_pkg::REFR_BITS-1:0] refractory_us;

  bit   shake_flags_q [$];               // predicted shake flag per accepted sample
  logic [asd_pkg::TIME_BITS-1:0] now_us; // running timestamp for generated samples

  bit idle_en;      // random idling on both sides
  bit sender_gaps;  // lets the pressure test keep the input saturated
  bit hold_req;     // asks the receiver for one long hold
  int n_errors;
  int n_samples;
  int n_results;
  int n_shakes;
  int n_writes;
  int dead_cycles;

  accel_shake_detector dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .in_time_us     (in_time_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_shake_seen (out_shake_seen)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // model of the block: one call per accepted sample transaction
  // --------------------------------------------------------------------------
  function automatic bit predict_shake(input sample_t s);
    longint      smp [3];
    longint      res;
    longint      prod;
    longint      g;
    longint      mag;
    logic [63:0] energy;
    logic [63:0] stamp;
    smp[0] = s.ax;
    smp[1] = s.ay;
    smp[2] = s.az;
    stamp  = {1'b0, s.t};
    // first sample after reset seeds the averages and never shakes
    if (!primed) begin
      foreach (smp[i]) gravity_est[i] = smp[i] * GRAV_ONE;
      primed = 1'b1;
      return 1'b0;
    end
    energy = '0;
    foreach (smp[i]) begin
      res  = smp[i] * GRAV_ONE - gravity_est[i];
      prod = res * longint'(follow_gain);
      // round half up, floor for negatives, then clamp to the average width
      g = gravity_est[i] + ((prod + GAIN_HALF) >>> asd_pkg::GAIN_FRAC_BITS);
      if (g > GRAV_MAX) g = GRAV_MAX;
      else if (g < GRAV_MIN) g = GRAV_MIN;
      gravity_est[i] = g;
      // residuals stay below 2^32 here, so squares and sum never saturate
      mag = (res < 0) ? -res : res;
      energy += 64'(mag * mag);
    end
    if ((energy >> (2 * asd_pkg::AVG_FRAC_BITS)) < 64'(threshold_sq)) return 1'b0;
    if (stamp < quiet_end_us) return 1'b0;
    // stamp < 2^63 and window < 2^32: the sum cannot wrap 64 bits
    quiet_end_us = stamp + 64'(refractory_us);
    return 1'b1;
  endfunction

  function automatic sample_t mk(input int x, input int y, input int z,
                                 input logic [asd_pkg::TIME_BITS-1:0] t);
    sample_t s;
    s.ax = asd_pkg::SAMPLE_BITS'(x);
    s.ay = asd_pkg::SAMPLE_BITS'(y);
    s.az = asd_pkg::SAMPLE_BITS'(z);
    s.t  = t;
    return s;
  endfunction

  // register write data from a plain number
  function automatic logic [asd_pkg::CFG_DATA_BITS-1:0] cfg_val(input longint v);
    return asd_pkg::CFG_DATA_BITS'(v);
  endfunction

  // --------------------------------------------------------------------------
  // shared driving tasks
  // --------------------------------------------------------------------------

  // one sample transaction; payload held until the block takes it
  task automatic send_sample(input sample_t s);
    if (sender_gaps && idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_accel_x <= s.ax;
    in_accel_y <= s.ay;
    in_accel_z <= s.az;
    in_time_us <= s.t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shake_flags_q.push_back(predict_shake(s));
    n_samples++;
  endtask

  // drop valid, let every predicted result come back, then a short tail
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shake_flags_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // register write, mirrored into the model; only called while idle
  task automatic write_reg(input logic [asd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [asd_pkg::CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      asd_pkg::REG_FOLLOW_GAIN:   follow_gain   = data[asd_pkg::GAIN_BITS-1:0];
      asd_pkg::REG_THRESHOLD_SQ:  threshold_sq  = data[asd_pkg::THR_BITS-1:0];
      asd_pkg::REG_REFRACTORY_US: refractory_us = data[asd_pkg::REFR_BITS-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // one setting per register, extremes weighted in
  task automatic pick_random_settings();
    logic [asd_pkg::CFG_DATA_BITS-1:0] gv;
    logic [asd_pkg::CFG_DATA_BITS-1:0] tv;
    logic [asd_pkg::CFG_DATA_BITS-1:0] rv;
    case ($urandom_range(0, 5))
      0:       gv = cfg_val(0);
      1:       gv = cfg_val(256);
      2:       gv = cfg_val(511);              // gain above unity overshoots
      3:       gv = cfg_val(51);
      default: gv = cfg_val($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 5))
      0:       tv = cfg_val(0);
      1:       tv = {asd_pkg::THR_BITS{1'b1}};
      2:       tv = asd_pkg::CFG_DATA_BITS'(asd_pkg::THR_RESET);
      3:       tv = {2'($urandom_range(0, 3)), $urandom};
      default: tv = cfg_val($urandom_range(0, 1 << 24));
    endcase
    case ($urandom_range(0, 5))
      0:       rv = cfg_val(0);
      1:       rv = cfg_val({asd_pkg::REFR_BITS{1'b1}});
      2:       rv = asd_pkg::CFG_DATA_BITS'(asd_pkg::REFR_RESET);
      3:       rv = cfg_val($urandom);
      default: rv = cfg_val($urandom_range(0, 2000000));
    endcase
    write_reg(asd_pkg::REG_FOLLOW_GAIN, gv);
    write_reg(asd_pkg::REG_THRESHOLD_SQ, tv);
    write_reg(asd_pkg::REG_REFRACTORY_US, rv);
  endtask

  // mostly forward in time, now and then a step back or a repeat
  task automatic advance_time();
    int back;
    if ($urandom_range(0, 19) == 0) begin
      back = $urandom_range(0, 5000);
      if (now_us > asd_pkg::TIME_BITS'(back)) now_us = now_us - asd_pkg::TIME_BITS'(back);
    end else begin
      now_us = now_us + asd_pkg::TIME_BITS'($urandom_range(0, 250000));
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings: priming, extremes, window entry and exit, time going back
  task automatic test_defaults_directed();
    send_sample(mk(32767, -32768, 0, 0));          // primes, never a shake
    send_sample(mk(32767, -32768, 0, 10));         // zero residual
    send_sample(mk(-32768, 32767, 0, 20));         // huge swing opens a window
    send_sample(mk(32767, -32768, 0, 500000));     // inside the window
    send_sample(mk(-32768, 32767, -32768, 1000020)); // exactly at window end
    send_sample(mk(32767, 32767, 32767, 100));     // timestamp went backward
    send_sample(mk(0, 0, 0, 3000000));
    send_sample(mk(-1, -1, -1, 3000001));
    send_sample(mk(1, 1, 1, 6000000));
    settle();
    now_us = 6000000;
  endtask

  // gain and threshold extremes, zero and full windows, unused register index
  task automatic test_register_extremes();
    write_reg(asd_pkg::REG_FOLLOW_GAIN, cfg_val(0));
    write_reg(asd_pkg::REG_THRESHOLD_SQ, cfg_val(0));
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val(0));
    // zero threshold and zero window: every sample shakes, averages frozen
    send_sample(mk(100, 200, 300, 7000000));
    send_sample(mk(100, 200, 300, 7000000));
    settle();
    // unity gain snaps the averages onto the sample
    write_reg(asd_pkg::REG_FOLLOW_GAIN, cfg_val(256));
    send_sample(mk(-32768, 32767, -32768, 7000001));
    send_sample(mk(-32768, 32767, -32768, 7000002));
    settle();
    // gain near 2: overshoot drives the averages into saturation
    write_reg(asd_pkg::REG_FOLLOW_GAIN, cfg_val(511));
    send_sample(mk(32767, -32768, 32767, 7000003));
    send_sample(mk(-32768, 32767, -32768, 7000004));
    send_sample(mk(32767, -32768, 32767, 7000005));
    settle();
    // largest threshold and window
    write_reg(asd_pkg::REG_THRESHOLD_SQ, {asd_pkg::THR_BITS{1'b1}});
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val({asd_pkg::REFR_BITS{1'b1}}));
    send_sample(mk(-32768, 32767, -32768, 7000006));
    send_sample(mk(32767, -32768, 32767, 7000007));
    send_sample(mk(-32768, 32767, -32768, 7000008));
    settle();
    // a write to an unmapped index must not disturb anything
    write_reg(REG_UNUSED, {asd_pkg::CFG_DATA_BITS{1'b1}});
    write_reg(asd_pkg::REG_FOLLOW_GAIN, asd_pkg::CFG_DATA_BITS'(asd_pkg::GAIN_RESET));
    write_reg(asd_pkg::REG_THRESHOLD_SQ, cfg_val(0));
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val(0));
    send_sample(mk(5, -5, 5, 7000009));
    send_sample(mk(-5, 5, -5, 7000010));
    settle();
    now_us = 7000010;
  endtask

  // quiet hand-held motion around a random gravity vector, with spikes
  task automatic test_random_motion(input int phases, input int per_phase);
    int      bx;
    int      by;
    int      bz;
    sample_t s;
    for (int p = 0; p < phases; p++) begin
      settle();
      pick_random_settings();
      bx = int'($urandom_range(0, 16384)) - 8192;
      by = int'($urandom_range(0, 16384)) - 8192;
      bz = int'($urandom_range(0, 16384)) - 8192;
      for (int k = 0; k < per_phase; k++) begin
        advance_time();
        if ($urandom_range(0, 5) == 0) begin
          s = mk(int'($urandom), int'($urandom), int'($urandom), now_us);
        end else begin
          s = mk(bx + int'($urandom_range(0, 600)) - 300,
                 by + int'($urandom_range(0, 600)) - 300,
                 bz + int'($urandom_range(0, 600)) - 300, now_us);
        end
        send_sample(s);
      end
    end
    settle();
  endtask

  // receiver holds for a long stretch while samples keep coming
  task automatic test_backpressure();
    write_reg(asd_pkg::REG_FOLLOW_GAIN, asd_pkg::CFG_DATA_BITS'(asd_pkg::GAIN_RESET));
    write_reg(asd_pkg::REG_THRESHOLD_SQ, cfg_val($urandom_range(0, 1 << 22)));
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val($urandom_range(0, 300000)));
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    for (int k = 0; k < 30; k++) begin
      advance_time();
      send_sample(mk(int'($urandom), int'($urandom), int'($urandom), now_us));
    end
    sender_gaps = 1'b1;
    settle();
  endtask

  // every field over its whole range, huge timestamps last since they
  // can push the window past any later timestamp
  task automatic test_full_range(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      settle();
      pick_random_settings();
      for (int k = 0; k < per_phase; k++) begin
        send_sample(mk(int'($urandom), int'($urandom), int'($urandom),
                       asd_pkg::TIME_BITS'({$urandom, $urandom})));
      end
    end
    settle();
    write_reg(asd_pkg::REG_THRESHOLD_SQ, cfg_val(0));
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val(0));
    send_sample(mk(-32768, -32768, -32768, {asd_pkg::TIME_BITS{1'b1}}));
    send_sample(mk(32767, 32767, 32767, {asd_pkg::TIME_BITS{1'b1}}));
    settle();
    write_reg(asd_pkg::REG_REFRACTORY_US, cfg_val({asd_pkg::REFR_BITS{1'b1}}));
    send_sample(mk(0, 0, 0, {asd_pkg::TIME_BITS{1'b1}}));
    send_sample(mk(-1, 0, 1, {asd_pkg::TIME_BITS{1'b1}}));
    send_sample(mk(1, 0, -1, 0));
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts plus one long hold on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result checker: each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_shake_seen) n_shakes++;
      if (shake_flags_q.size() == 0) begin
        $error("unexpected result transaction: shake_seen actual %0b",
               out_shake_seen);
        n_errors++;
      end else if (shake_flags_q[0] !== out_shake_seen) begin
        $error("shake_seen mismatch: expected %0b actual %0b",
               shake_flags_q[0], out_shake_seen);
        n_errors++;
        void'(shake_flags_q.pop_front());
      end else begin
        void'(shake_flags_q.pop_front());
      end
    end
  end

  // watchdog: a hung handshake on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= DEAD_LIMIT) begin
      $display("timeout: %0d predictions still pending", shake_flags_q.size());
      $display("accel_shake_detector regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    // model reset state and register defaults
    foreach (gravity_est[i]) gravity_est[i] = 0;
    primed        = 1'b0;
    quiet_end_us  = '0;
    follow_gain   = asd_pkg::GAIN_RESET;
    threshold_sq  = asd_pkg::THR_RESET;
    refractory_us = asd_pkg::REFR_RESET;
    now_us        = '0;
    idle_en       = 1'b1;
    sender_gaps   = 1'b1;
    hold_req      = 1'b0;
    n_errors      = 0;
    n_samples     = 0;
    n_results     = 0;
    n_shakes      = 0;
    n_writes      = 0;
    dead_cycles   = 0;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= asd_pkg::REG_FOLLOW_GAIN;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_accel_x <= '0;
    in_accel_y <= '0;
    in_accel_z <= '0;
    in_time_us <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_directed();
    test_register_extremes();
    test_random_motion(5, 200);
    test_backpressure();
    // last stretch runs with no idling on either side
    idle_en = 1'b0;
    test_full_range(5, 50);
    settle();

    $display("run covered %0d samples, %0d results, %0d shakes, %0d register writes",
             n_samples, n_results, n_shakes, n_writes);
    $display("settings swept gain 0 to 511, threshold and window 0 to max, one long hold");
    if (n_errors == 0)
      $display("accel_shake_detector regression: pass");
    else
      $display("accel_shake_detector regression: fail");
    $finish;
  end

endmodule
